// File: rtl/des_pkg.sv
// Shared types, constants and helper functions of the double exponential smoother.
// No dependencies; every other file of the block depends on this package.
package des_pkg;

  localparam int SAMPLE_W = 16;
  localparam int Q_W      = 32;   // Q16.16 level, trend, forecast
  localparam int GAIN_W   = 17;   // unsigned Q1.16
  localparam int WIDE_W   = 33;   // sums and differences of two Q16.16 values
  localparam int PROD_W   = 51;   // 18-bit signed gain times 33-bit operand
  localparam int RND_W    = 35;   // rounded product, PROD_W - 16
  localparam int ACC_W    = 36;   // sum of two rounded terms, before saturation
  localparam int CFG_IDX_W = 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [Q_W-1:0]      q16_t;
  typedef logic        [GAIN_W-1:0]   gain_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [RND_W-1:0]    rnd_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  localparam gain_t GAIN_ONE   = 17'd65536;
  localparam gain_t GAIN_RESET = 17'd32768;

  localparam cfg_idx_t REG_LEVEL_GAIN = 1'd0;
  localparam cfg_idx_t REG_TREND_GAIN = 1'd1;

  localparam acc_t SAT_HI = 36'sd2147483647;
  localparam acc_t SAT_LO = -36'sd2147483648;
  localparam prod_t RND_HALF = 51'sd32768;

  // Operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    MUL_LVL_HOLD   = 2'd0,   // (1 - alpha) * (prev_level + prev_trend)
    MUL_LVL_SAMPLE = 2'd1,   // alpha * sample
    MUL_TRD_DIFF   = 2'd2,   // beta * (level - prev_level)
    MUL_TRD_HOLD   = 2'd3    // (1 - beta) * prev_trend
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;   // capture sample, form prev_level + prev_trend
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;    // acc <= rnd(prod)
    logic     level_en;  // level <= sat(acc + prod)
    logic     diff_en;   // diff <= level - prev_level
    logic     trend_en;  // trend <= sat(acc + rnd(prod))
    logic     commit;    // prev_level <= forecast, prev_trend <= trend
  } dp_cmd_t;

  function automatic q16_t sat32(input acc_t v);
    if (v > SAT_HI) return q16_t'(SAT_HI[Q_W-1:0]);
    if (v < SAT_LO) return q16_t'(SAT_LO[Q_W-1:0]);
    return v[Q_W-1:0];
  endfunction

  // floor((p + 0.5 lsb) / 2^16)
  function automatic rnd_t rnd16(input prod_t p);
    prod_t t;
    t = p + RND_HALF;
    return t[PROD_W-1:16];
  endfunction

  // Gains above one are taken as one
  function automatic gain_t eff_gain(input gain_t g);
    return g[GAIN_W-1] ? GAIN_ONE : g;
  endfunction

endpackage

// File: rtl/des_if.sv
// Handshake channels of the smoother: sample words in, forecast/trend words out.
// Depends on des_pkg.
interface des_in_if;
  logic              valid;
  logic              ready;
  des_pkg::sample_t  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface des_out_if;
  logic          valid;
  logic          ready;
  des_pkg::q16_t forecast;
  des_pkg::q16_t trend;
  modport source (output valid, output forecast, output trend, input ready);
  modport sink   (input valid, input forecast, input trend, output ready);
endinterface

// File: rtl/des_ctrl.sv
// Sequencer of the smoother: steps one word through the shared multiplier.
// Depends on des_pkg; drives des_datapath through dp_cmd_t.
module des_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output des_pkg::dp_cmd_t cmd
);
  import des_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_M1, ST_M2, ST_LEVEL, ST_DIFF, ST_M3, ST_M4, ST_TREND, ST_COMMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_LVL_HOLD;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_M1;
        end
      end
      ST_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LVL_HOLD;
        state_next  = ST_M2;
      end
      ST_M2: begin
        cmd.acc_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LVL_SAMPLE;
        state_next  = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd.level_en = 1'b1;
        state_next   = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = ST_M3;
      end
      ST_M3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TRD_DIFF;
        state_next  = ST_M4;
      end
      ST_M4: begin
        cmd.acc_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TRD_HOLD;
        state_next  = ST_TREND;
      end
      ST_TREND: begin
        cmd.trend_en = 1'b1;
        state_next   = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/des_datapath.sv
// Datapath of the smoother: gain registers, state, one shared multiplier and
// rounding/saturation adders. Depends on des_pkg; commanded by des_ctrl.
module des_datapath (
  input  logic             clk,
  input  logic             rst,
  input  des_pkg::dp_cmd_t cmd,
  input  des_pkg::sample_t in_sample,
  input  logic             cfg_we,
  input  des_pkg::cfg_idx_t cfg_index,
  input  des_pkg::gain_t   cfg_data,
  output des_pkg::q16_t    forecast,
  output des_pkg::q16_t    trend
);
  import des_pkg::*;

  gain_t level_gain;
  gain_t trend_gain;
  q16_t  prev_level;
  q16_t  prev_trend;

  sample_t smp;
  wide_t   sum;
  prod_t   prod;
  rnd_t    acc;
  q16_t    level;
  wide_t   diff;
  q16_t    trend_new;

  gain_t alpha, beta, alpha_c, beta_c;
  logic signed [GAIN_W:0] mul_a;
  wide_t   mul_b;
  prod_t   prod_next;
  acc_t    level_sum, trend_sum, fc_sum;

  assign alpha   = eff_gain(level_gain);
  assign beta    = eff_gain(trend_gain);
  assign alpha_c = GAIN_ONE - alpha;
  assign beta_c  = GAIN_ONE - beta;

  always_comb begin
    case (cmd.mul_sel)
      MUL_LVL_HOLD: begin
        mul_a = {1'b0, alpha_c};
        mul_b = sum;
      end
      MUL_LVL_SAMPLE: begin
        mul_a = {1'b0, alpha};
        mul_b = WIDE_W'(smp);
      end
      MUL_TRD_DIFF: begin
        mul_a = {1'b0, beta};
        mul_b = diff;
      end
      MUL_TRD_HOLD: begin
        mul_a = {1'b0, beta_c};
        mul_b = WIDE_W'(prev_trend);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

  // alpha * sample is exact Q16.16 and fits in RND_W bits
  assign level_sum = ACC_W'(acc) + ACC_W'(rnd_t'(prod[RND_W-1:0]));
  assign trend_sum = ACC_W'(acc) + ACC_W'(rnd16(prod));
  assign fc_sum    = ACC_W'(level) + ACC_W'(trend_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      level_gain <= GAIN_RESET;
      trend_gain <= GAIN_RESET;
      prev_level <= '0;
      prev_trend <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEVEL_GAIN: level_gain <= cfg_data;
          REG_TREND_GAIN: trend_gain <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        prev_level <= sat32(fc_sum);
        prev_trend <= trend_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp <= in_sample;
      sum <= WIDE_W'(prev_level) + WIDE_W'(prev_trend);
    end
    if (cmd.mul_en)   prod      <= prod_next;
    if (cmd.acc_en)   acc       <= rnd16(prod);
    if (cmd.level_en) level     <= sat32(level_sum);
    if (cmd.diff_en)  diff      <= WIDE_W'(level) - WIDE_W'(prev_level);
    if (cmd.trend_en) trend_new <= sat32(trend_sum);
  end

  // The stored state is the result: it changes only when the output slot is free
  assign forecast = prev_level;
  assign trend    = prev_trend;

endmodule

// File: rtl/double_exponential_smoother_core.sv
// Top level of the double exponential smoother (Holt style, forecast fed back).
// Depends on des_pkg, des_if, des_ctrl and des_datapath.
//
//  channel   dir  handshake          payload
//  in_ch     in   valid / ready      sample   (s16, integer taken as Q16.16)
//  out_ch    out  valid / ready      forecast (s32 Q16.16), trend (s32 Q16.16)
//  cfg       in   cfg_we             cfg_index (0 level_gain, 1 trend_gain), cfg_data
//
// Sequence: a word passes an accept step and eight steps (M1, M2, LEVEL, DIFF,
// M3, M4, TREND, COMMIT); the single shared 18x33 multiplier, used four times
// in series, sets that sequence. No new word is taken until the last commits.
// Reset (rst, synchronous): gains to 0.5, level and trend to zero, no result.
// Stalls: the next word is accepted while a result waits on out_ch; its final
// step holds until the previous result has been taken.
module double_exponential_smoother_core (
  input  logic              clk,
  input  logic              rst,
  des_in_if.sink           in_ch,
  des_out_if.source        out_ch,
  input  logic              cfg_we,
  input  des_pkg::cfg_idx_t cfg_index,
  input  des_pkg::gain_t    cfg_data
);
  import des_pkg::*;

  dp_cmd_t cmd;

  // Sequencer: walks level, then trend through the multiplier, then commits the forecast
  des_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Datapath: the stored forecast/trend pair doubles as the output register
  des_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_sample (in_ch.sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .forecast  (out_ch.forecast),
    .trend     (out_ch.trend)
  );

endmodule

// File: rtl/des_checker.sv
// Port-level checks of the smoother, bound to the top level.
// Depends on des_pkg; sees only the top level's ports.
module des_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input des_pkg::q16_t forecast,
  input des_pkg::q16_t trend
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(forecast) && $stable(trend))
    else $error("result word changed while stalled");

  // One word in flight: no acceptance right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

  // With the output empty after an acceptance, a new result does not follow at once
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 !out_valid |-> ##1 !out_valid)
    else $error("result appeared too early");

  // Result state is cleared by reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && forecast == '0 && trend == '0)
    else $error("result present after reset");

endmodule

bind double_exponential_smoother_core des_checker u_des_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .forecast  (out_ch.forecast),
  .trend     (out_ch.trend)
);
